/* design/smfr_pkg.sv */
// ----------------------------------------------------------------------------
// smfr_pkg: shared constants for the sliding median frame rate block
// Field widths, window default and the fixed-point rate numerator.
// ----------------------------------------------------------------------------
package smfr_pkg;

  localparam int NS_W           = 32;  // elapsed interval width
  localparam int RATE_W         = 24;  // Q16.8 rate width
  localparam int WINDOW_DEFAULT = 30;  // rates held in the window
  localparam int GROUP_SIZE     = 8;   // cells per first-level count group
  localparam int GROUP_CNT_W    = 4;   // holds 0..GROUP_SIZE

  // 1e9 ns per second times 256 for the Q16.8 scale
  localparam logic [37:0] RATE_NUM = 38'd256000000000;

  // Upper bits of the numerator: any interval at or below this value gives a
  // quotient of 2^RATE_W or more and so saturates.
  localparam logic [37-RATE_W:0] RATE_NUM_HI = RATE_NUM[37:RATE_W];
  localparam logic [RATE_W-1:0]  RATE_NUM_LO = RATE_NUM[RATE_W-1:0];
  localparam logic [RATE_W-1:0]  RATE_MAX    = '1;

endpackage

/* design/sliding_median_frame_rate.sv */
// ----------------------------------------------------------------------------
// sliding_median_frame_rate: median frame rate over a sliding window
// Turns frame intervals into Q16.8 rates and reports the window median.
// ----------------------------------------------------------------------------
// Usage
//   Sample channel: sample_valid / sample_stall carry elapsed_ns, the time
//   in nanoseconds since the previous frame. A transfer happens when valid is
//   high and stall is low. A zero interval is taken and dropped: no result,
//   no change to the window, and the next sample may follow at once.
//   Median channel: median_valid / median_stall carry median_rate, the median
//   of the last WINDOW rates in unsigned Q16.8, saturated to 24 bits.
// Sequence
//   Each non-zero sample goes through bit-serial restoring division (skipped
//   when the rate saturates), a write of the window, radix selection (per
//   rate bit, one step for the grouped zero counts and one to settle the bit)
//   and a load of the output register. The next sample may be taken as soon
//   as median_valid rises.
// Reset and stall
//   rst (synchronous) empties the window and drops any pending result.
//   The result sits in an output register; a new sample may be taken while
//   it waits, and that sample holds in its final step until the register is
//   free.
// ----------------------------------------------------------------------------
module sliding_median_frame_rate import smfr_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  logic [NS_W-1:0]   elapsed_ns,
  output logic              median_valid,
  input  logic              median_stall,
  output logic [RATE_W-1:0] median_rate
);

  localparam int CW     = $clog2(WINDOW + 1);            // count of entries
  localparam int SW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;  // slot index
  localparam int GROUPS = (WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int STEP_W = $clog2(RATE_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_INS,
    S_CNT,
    S_SEL,
    S_DONE
  } state_t;

  state_t state;

  // window cells, rotated left one bit per selection step so the bit under
  // test always sits in the MSB
  logic [RATE_W-1:0] cells [WINDOW];
  logic [WINDOW-1:0] alive;   // cells still matching the median prefix
  logic [CW-1:0]     fill;
  logic [SW-1:0]     oldest;
  logic [CW-1:0]     rank;    // remaining rank among alive cells

  // divider
  logic [NS_W-1:0]   divisor;
  logic [NS_W-1:0]   rem;
  logic [RATE_W-1:0] num_lo;
  logic [RATE_W-1:0] quot;
  logic [STEP_W-1:0] step;

  logic [RATE_W-1:0]      med;
  logic [GROUP_CNT_W-1:0] grp [GROUPS];

  // divider step
  logic [NS_W:0]   trial;
  logic            trial_ge;
  logic [NS_W:0]   trial_diff;
  logic [NS_W-1:0] rem_next;

  always_comb begin
    trial      = {rem, num_lo[RATE_W-1]};
    trial_ge   = (trial >= {1'b0, divisor});
    trial_diff = trial - {1'b0, divisor};
    rem_next   = trial_ge ? trial_diff[NS_W-1:0] : trial[NS_W-1:0];
  end

  // zero bits among alive cells, per group
  logic [WINDOW-1:0]      zero_bits;
  logic [GROUP_CNT_W-1:0] grp_next [GROUPS];

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      zero_bits[i] = alive[i] & ~cells[i][RATE_W-1];
    end
    for (int g = 0; g < GROUPS; g++) begin
      grp_next[g] = '0;
      for (int e = 0; e < GROUP_SIZE; e++) begin
        if (g * GROUP_SIZE + e < WINDOW) begin
          grp_next[g] = grp_next[g] + GROUP_CNT_W'(zero_bits[g * GROUP_SIZE + e]);
        end
      end
    end
  end

  // total zeros among alive cells from the registered group counts
  logic [CW-1:0] zero_sum;

  always_comb begin
    zero_sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      zero_sum = zero_sum + CW'(grp[g]);
    end
  end

  // window bookkeeping for the insert step
  logic          win_full;
  logic [SW-1:0] slot;
  logic [CW-1:0] count_new;

  always_comb begin
    win_full  = (fill == CW'(WINDOW));
    slot      = win_full ? oldest : fill[SW-1:0];
    count_new = win_full ? fill : fill + CW'(1);
  end

  logic bit_zero;
  assign bit_zero = (rank < zero_sum);

  logic sample_xfer;
  assign sample_xfer  = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      oldest       <= '0;
      median_valid <= 1'b0;
    end else begin
      // release the output register once its transfer completes, unless
      // the done step reloads it in this cycle
      if (median_valid && !median_stall && (state != S_DONE)) begin
        median_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_xfer && (elapsed_ns != '0)) begin
            divisor <= elapsed_ns;
            rem     <= NS_W'(RATE_NUM_HI);
            num_lo  <= RATE_NUM_LO;
            step    <= '0;
            if (elapsed_ns <= NS_W'(RATE_NUM_HI)) begin
              // fast frame: saturate and skip the division
              quot  <= RATE_MAX;
              state <= S_INS;
            end else begin
              state <= S_DIV;
            end
          end
        end

        S_DIV: begin
          rem    <= rem_next;
          num_lo <= {num_lo[RATE_W-2:0], 1'b0};
          quot   <= {quot[RATE_W-2:0], trial_ge};
          if (step == STEP_W'(RATE_W - 1)) begin
            state <= S_INS;
          end else begin
            step <= step + STEP_W'(1);
          end
        end

        S_INS: begin
          cells[slot] <= quot;
          fill        <= count_new;
          if (win_full) begin
            oldest <= (oldest == SW'(WINDOW - 1)) ? '0 : oldest + SW'(1);
          end
          for (int i = 0; i < WINDOW; i++) begin
            alive[i] <= (CW'(i) < count_new);
          end
          rank  <= count_new >> 1;
          step  <= '0;
          state <= S_CNT;
        end

        S_CNT: begin
          for (int g = 0; g < GROUPS; g++) begin
            grp[g] <= grp_next[g];
          end
          state <= S_SEL;
        end

        S_SEL: begin
          // settle one median bit, narrow the candidates, rotate the cells
          med <= {med[RATE_W-2:0], ~bit_zero};
          if (!bit_zero) begin
            rank <= rank - zero_sum;
          end
          for (int i = 0; i < WINDOW; i++) begin
            alive[i] <= alive[i] & (cells[i][RATE_W-1] ^ bit_zero);
            cells[i] <= {cells[i][RATE_W-2:0], cells[i][RATE_W-1]};
          end
          if (step == STEP_W'(RATE_W - 1)) begin
            state <= S_DONE;
          end else begin
            step  <= step + STEP_W'(1);
            state <= S_CNT;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!median_valid || !median_stall) begin
            median_rate  <= med;
            median_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only appears after the selection has finished
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(median_valid) |-> $past(state == S_DONE))
    else $error("median result raised outside the done step");

  // a zero interval leaves the window untouched
  a_zero_no_change: assert property (@(posedge clk) disable iff (rst)
    (sample_xfer && (elapsed_ns == '0)) |=> ($stable(fill) && $stable(oldest)))
    else $error("zero interval changed the window");

  // the rank search never runs out of candidates
  a_alive_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL) |-> (alive != '0))
    else $error("median selection lost every candidate");

  // the window never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |=> (fill <= CW'(WINDOW)) && (fill != '0))
    else $error("window fill count out of range");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for sliding_median_frame_rate
// Drives frame intervals on the sample channel with random gaps. A scoreboard
// keeps its own window of rates and predicts each median. Medians are taken
// under random stall and checked in order.
// ----------------------------------------------------------------------------
module tb import smfr_pkg::*; ();

  // Cycles with no transfer on either channel before the run is abandoned.
  // A heavy receiver stall lengthens a sample only a little, so this
  // is many times the slowest correct gap.
  localparam int WATCHDOG_LIMIT = 5000;
  // Cycles to wait once all medians have arrived, for any stray result.
  localparam int DRAIN_CYCLES   = 200;
  // Intervals per idling phase (three phases), zero intervals included.
  localparam int PHASE_ITEMS    = 417;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the rate window and a queue of pending medians
  // --------------------------------------------------------------------------
  class median_scoreboard;
    logic [RATE_W-1:0] rates [WINDOW_DEFAULT];
    int unsigned       filled;
    int unsigned       oldest;
    logic [RATE_W-1:0] pending [$];
    int unsigned       errors;
    int unsigned       medians_checked;
    int unsigned       zero_intervals;
    int unsigned       saturated;
    int unsigned       overwrites;

    function new();
      filled = 0;
      oldest = 0;
      errors = 0;
      medians_checked = 0;
      zero_intervals = 0;
      saturated = 0;
      overwrites = 0;
    endfunction

    // Q16.8 rate, truncated, clamped to the field width
    function logic [RATE_W-1:0] rate_of(input logic [NS_W-1:0] ns);
      logic [63:0] quot;
      quot = {26'd0, RATE_NUM} / {32'd0, ns};
      if (quot > {40'd0, RATE_MAX}) begin
        saturated++;
        return RATE_MAX;
      end
      return quot[RATE_W-1:0];
    endfunction

    // Element of rank filled/2 among the filled entries
    function logic [RATE_W-1:0] window_median();
      logic [RATE_W-1:0] sorted [WINDOW_DEFAULT];
      logic [RATE_W-1:0] key;
      int                i;
      int                j;
      for (i = 0; i < filled; i++) sorted[i] = rates[i];
      for (i = 1; i < filled; i++) begin
        key = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = key;
      end
      return sorted[filled / 2];
    endfunction

    // Accepted interval: advance the window and queue the median it causes
    function void note_sample(input logic [NS_W-1:0] ns);
      logic [RATE_W-1:0] rate;
      if (ns == '0) begin
        zero_intervals++;
        return;
      end
      rate = rate_of(ns);
      if (filled < WINDOW_DEFAULT) begin
        rates[filled] = rate;
        filled++;
      end else begin
        rates[oldest] = rate;
        oldest = (oldest + 1) % WINDOW_DEFAULT;
        overwrites++;
      end
      pending.push_back(window_median());
    endfunction

    task report(input string what, input logic [RATE_W-1:0] want,
                input logic [RATE_W-1:0] got);
      $display("MISMATCH %s: expected 0x%06h got 0x%06h", what, want, got);
      errors++;
    endtask

    // Accepted median: compare with the oldest prediction
    task check_median(input logic [RATE_W-1:0] got);
      logic [RATE_W-1:0] want;
      if (pending.size() == 0) begin
        report("median with none pending", '0, got);
      end else begin
        want = pending.pop_front();
        medians_checked++;
        if (got !== want) report("median_rate", want, got);
      end
    endtask

    task check_leftovers();
      while (pending.size() != 0) report("median never delivered", pending.pop_front(), '0);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  logic [NS_W-1:0]   elapsed_ns;
  logic              median_valid;
  logic              median_stall;
  logic [RATE_W-1:0] median_rate;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_median_frame_rate uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .elapsed_ns   (elapsed_ns),
    .median_valid (median_valid),
    .median_stall (median_stall),
    .median_rate  (median_rate)
  );

  median_scoreboard sb = new();

  int unsigned     send_idle_pct;   // chance per cycle that the sender holds off
  int unsigned     recv_stall_pct;  // chance per cycle that the receiver stalls
  int unsigned     idle_cycles;
  logic [NS_W-1:0] last_ns;

  // --------------------------------------------------------------------------
  // Receiver: raise stall at random on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    median_stall = ($urandom_range(0, 99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: note transfers on both channels at the rising edge. The input
  // side is noted first so a prediction is always queued before its result.
  // The watchdog counts cycles in which neither channel moves a transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else if (!rst) begin
      idle_cycles++;
      if (sample_valid && !sample_stall) begin
        sb.note_sample(elapsed_ns);
        idle_cycles = 0;
      end
      if (median_valid && !median_stall) begin
        sb.check_median(median_rate);
        idle_cycles = 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: hold off at random, then present the interval and wait for the
  // transfer. Valid stays high between back-to-back samples.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic [NS_W-1:0] ns);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    elapsed_ns   = ns;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    last_ns = ns;
    @(negedge clk);
  endtask

  // Mostly steady frame timing with jitter, plus saturating, boundary,
  // repeated, zero and fully random intervals.
  function automatic logic [NS_W-1:0] pick_interval();
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0:       base = 16666667;  // 60 fps
      1:       base = 33333333;  // 30 fps
      2:       base = 8333333;   // 120 fps
      default: base = 41666667;  // 24 fps
    endcase
    if (pick < 60)      return base - 200000 + $urandom_range(0, 400000);
    else if (pick < 70) return $urandom;
    else if (pick < 78) return $urandom_range(1, 15258);
    else if (pick < 85) return $urandom_range(15250, 15270);
    else if (pick < 90) return '0;
    else                return last_ns;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  logic [NS_W-1:0] directed [$] = '{
    32'd0,                       // zero interval before anything is stored
    32'd1,                       // fastest frame, saturates
    32'd15258,                   // last saturating interval
    32'd15259,                   // first unsaturated interval
    32'd15260,
    32'd0,                       // zero interval with a partly filled window
    32'hFFFF_FFFF,               // longest interval, slowest rate
    32'd16666667,
    32'd16666667,                // repeated rate
    32'd33333333,
    32'd256000000,               // exact quotient
    32'd1000000000,
    32'h8000_0000,
    32'h7FFF_FFFF,
    32'h5555_5555,
    32'hAAAA_AAAA,
    32'd2,
    32'd250000,
    32'd0,
    32'd3
  };

  initial begin
    int unsigned     phase;
    int unsigned     sent;
    logic [NS_W-1:0] ns;

    rst            = 1'b1;
    sample_valid   = 1'b0;
    elapsed_ns     = '0;
    median_stall   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    idle_cycles    = 0;
    last_ns        = 32'd16666667;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Phase 0: sender idles a little, receiver stalls a lot.
    // Phase 1: the other way round. Phase 2: full speed both sides.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 15; recv_stall_pct = 70; end
        1:       begin send_idle_pct = 70; recv_stall_pct = 15; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (phase == 0) begin
        foreach (directed[i]) send_sample(directed[i]);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        ns = pick_interval();
        send_sample(ns);
        sent++;
      end
    end

    // Drop valid, let every prediction arrive, then watch for strays
    sample_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftovers();

    $display("Covered %0d medians, %0d zero intervals, %0d saturated rates,",
             sb.medians_checked, sb.zero_intervals, sb.saturated);
    $display("%0d window overwrites, under three sender and receiver idling mixes",
             sb.overwrites);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/smfr_pkg.sv
design/sliding_median_frame_rate.sv
tb/tb.sv
